// ===== src/assert_macros.svh =====
// Assertion macros shared by the maze solver RTL.
// Each use sits on a line of its own and takes a label and a property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every rising clock edge, skip while reset is applied
`define GM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gmdfs assertion failed");
// Check on every rising clock edge, reset included
`define GM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("gmdfs assertion failed");
`else
`define GM_ASSERT(lbl, prop)
`define GM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== src/gmdfs_pkg.sv =====
package gmdfs_pkg;

  // Default maze bounds
  localparam int unsigned MAX_ROWS_DEF = 64;
  localparam int unsigned MAX_COLS_DEF = 64;

  // Field widths
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned EPOCH_W = 8;

  // Register indexes and reset values
  localparam logic             CFG_ROWS  = 1'b0;
  localparam logic             CFG_COLS  = 1'b1;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SOLVE = 2'd1,
    OP_TRACE = 2'd2
  } gmdfs_op_e;

  // Direction a cell was entered by
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } gmdfs_dir_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_START_RD,
    ST_START_WR,
    ST_POP,
    ST_CHECK,
    ST_NB_ISSUE,
    ST_NB_EVAL,
    ST_TRACE_RD,
    ST_TRACE_EVAL,
    ST_RESULT
  } gmdfs_state_e;

  typedef struct packed {
    gmdfs_op_e          op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               wall;
    logic [COORD_W-1:0] goal_row;
    logic [COORD_W-1:0] goal_col;
  } gmdfs_req_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] path_row;
    logic [COORD_W-1:0] path_col;
    logic               last_of_path;
  } gmdfs_rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0] rows_in_use;
    logic [CFG_W-1:0] cols_in_use;
  } gmdfs_cfg_t;

  // One word of the cell memory; tag equal to the live epoch means visited
  typedef struct packed {
    logic               wall;
    gmdfs_dir_e         dir;
    logic [EPOCH_W-1:0] tag;
  } gmdfs_cell_t;

  // Handshake toward the core
  typedef struct packed {
    logic req_valid;
    logic rsp_ready;
  } gmdfs_ctl_t;

  // Handshake from the core
  typedef struct packed {
    logic req_ready;
    logic rsp_valid;
  } gmdfs_sts_t;

endpackage

// ===== src/gmdfs_core.sv =====
`include "assert_macros.svh"

module gmdfs_core #(
  parameter int unsigned MAX_ROWS = gmdfs_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = gmdfs_pkg::MAX_COLS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gmdfs_pkg::gmdfs_cfg_t  cfg_i,
  input  gmdfs_pkg::gmdfs_ctl_t  ctl_i,
  output gmdfs_pkg::gmdfs_sts_t  sts_o,
  input  gmdfs_pkg::gmdfs_req_t  req_i,
  output gmdfs_pkg::gmdfs_rsp_t  rsp_o
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 2 ** AW;
  localparam int DRW   = (RW + 1 > gmdfs_pkg::CFG_W) ? RW + 1 : gmdfs_pkg::CFG_W;
  localparam int DCW   = (CW + 1 > gmdfs_pkg::CFG_W) ? CW + 1 : gmdfs_pkg::CFG_W;
  localparam int GRW   = (RW > gmdfs_pkg::COORD_W) ? RW : gmdfs_pkg::COORD_W;
  localparam int GCW   = (CW > gmdfs_pkg::COORD_W) ? CW : gmdfs_pkg::COORD_W;
  localparam int EW    = gmdfs_pkg::EPOCH_W;

  gmdfs_pkg::gmdfs_state_e state_q, state_d;
  logic [EW-1:0]           epoch_q, epoch_d;
  logic                    pend_q, pend_d;
  logic [AW:0]             clr_q, clr_d;
  logic [AW:0]             sp_q, sp_d;
  logic [AW-1:0]           trace_q, trace_d;
  logic [AW-1:0]           start_q, start_d;
  logic                    path_q, path_d;
  gmdfs_pkg::gmdfs_req_t   req_q, req_d;
  gmdfs_pkg::gmdfs_dir_e   dir_q, dir_d;
  logic [AW-1:0]           nb_q, nb_d;
  gmdfs_pkg::gmdfs_rsp_t   rsp_q, rsp_d;

  // Cell memory: wall, arrival direction, visited epoch
  gmdfs_pkg::gmdfs_cell_t  cell_mem [DEPTH];
  logic                    cm_we, cm_re;
  logic [AW-1:0]           cm_waddr, cm_raddr;
  gmdfs_pkg::gmdfs_cell_t  cm_wdata, cm_rdata_q;

  // Search stack memory
  logic [AW-1:0]           stack_mem [DEPTH];
  logic                    st_we, st_re;
  logic [AW-1:0]           st_waddr, st_raddr, st_wdata, st_rdata_q;

  logic [DRW-1:0]          nr;
  logic [DCW-1:0]          nc;
  logic [RW-1:0]           cur_r, nb_r, trc_r, prev_r;
  logic [CW-1:0]           cur_c, nb_c, trc_c, prev_c;
  logic                    nb_ok, prev_ok, goal_hit, start_ok, load_ok, epoch_full;
  logic [AW-1:0]           in_addr, req_addr;

  // Clamp the dimensions in use to 1..MAX
  always_comb begin
    if (cfg_i.rows_in_use == '0) begin
      nr = DRW'(1);
    end else if (DRW'(cfg_i.rows_in_use) > DRW'(MAX_ROWS)) begin
      nr = DRW'(MAX_ROWS);
    end else begin
      nr = DRW'(cfg_i.rows_in_use);
    end
    if (cfg_i.cols_in_use == '0) begin
      nc = DCW'(1);
    end else if (DCW'(cfg_i.cols_in_use) > DCW'(MAX_COLS)) begin
      nc = DCW'(MAX_COLS);
    end else begin
      nc = DCW'(cfg_i.cols_in_use);
    end
  end

  assign cur_r    = st_rdata_q[AW-1:CW];
  assign cur_c    = st_rdata_q[CW-1:0];
  assign trc_r    = trace_q[AW-1:CW];
  assign trc_c    = trace_q[CW-1:0];
  assign in_addr  = {RW'(req_i.row), CW'(req_i.col)};
  assign req_addr = {RW'(req_q.row), CW'(req_q.col)};

  assign start_ok = (DRW'(req_i.row) < nr) && (DCW'(req_i.col) < nc);
  assign load_ok  = (DRW'(req_i.row) < DRW'(MAX_ROWS)) &&
                    (DCW'(req_i.col) < DCW'(MAX_COLS));
  assign goal_hit = (GRW'(cur_r) == GRW'(req_q.goal_row)) &&
                    (GCW'(cur_c) == GCW'(req_q.goal_col));
  assign epoch_full = (epoch_q == '1);

  // Neighbor of the popped cell in the current direction
  always_comb begin
    nb_ok = 1'b0;
    nb_r  = cur_r;
    nb_c  = cur_c;
    case (dir_q)
      gmdfs_pkg::DIR_UP: begin
        nb_ok = (cur_r != '0);
        nb_r  = cur_r - RW'(1);
      end
      gmdfs_pkg::DIR_DOWN: begin
        nb_ok = (DRW'(cur_r) + DRW'(1)) < nr;
        nb_r  = cur_r + RW'(1);
      end
      gmdfs_pkg::DIR_LEFT: begin
        nb_ok = (cur_c != '0);
        nb_c  = cur_c - CW'(1);
      end
      gmdfs_pkg::DIR_RIGHT: begin
        nb_ok = (DCW'(cur_c) + DCW'(1)) < nc;
        nb_c  = cur_c + CW'(1);
      end
      default: ;
    endcase
  end

  // Step back against the arrival direction of the traced cell
  always_comb begin
    prev_ok = 1'b0;
    prev_r  = trc_r;
    prev_c  = trc_c;
    case (cm_rdata_q.dir)
      gmdfs_pkg::DIR_UP: begin
        prev_ok = (DRW'(trc_r) + DRW'(1)) < DRW'(MAX_ROWS);
        prev_r  = trc_r + RW'(1);
      end
      gmdfs_pkg::DIR_DOWN: begin
        prev_ok = (trc_r != '0);
        prev_r  = trc_r - RW'(1);
      end
      gmdfs_pkg::DIR_LEFT: begin
        prev_ok = (DCW'(trc_c) + DCW'(1)) < DCW'(MAX_COLS);
        prev_c  = trc_c + CW'(1);
      end
      gmdfs_pkg::DIR_RIGHT: begin
        prev_ok = (trc_c != '0);
        prev_c  = trc_c - CW'(1);
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gmdfs_pkg::ST_CLEAR: begin
        if (clr_q[AW]) begin
          state_d = pend_q ? gmdfs_pkg::ST_START_RD : gmdfs_pkg::ST_IDLE;
        end
      end
      gmdfs_pkg::ST_IDLE: begin
        if (ctl_i.req_valid) begin
          case (req_i.op)
            gmdfs_pkg::OP_LOAD: begin
              state_d = load_ok ? gmdfs_pkg::ST_LOAD_RD : gmdfs_pkg::ST_RESULT;
            end
            gmdfs_pkg::OP_SOLVE: begin
              if (!start_ok) begin
                state_d = gmdfs_pkg::ST_RESULT;
              end else if (epoch_full) begin
                state_d = gmdfs_pkg::ST_CLEAR;
              end else begin
                state_d = gmdfs_pkg::ST_START_RD;
              end
            end
            gmdfs_pkg::OP_TRACE: begin
              state_d = path_q ? gmdfs_pkg::ST_TRACE_RD : gmdfs_pkg::ST_RESULT;
            end
            default: state_d = gmdfs_pkg::ST_RESULT;
          endcase
        end
      end
      gmdfs_pkg::ST_LOAD_RD:    state_d = gmdfs_pkg::ST_LOAD_WR;
      gmdfs_pkg::ST_LOAD_WR:    state_d = gmdfs_pkg::ST_RESULT;
      gmdfs_pkg::ST_START_RD:   state_d = gmdfs_pkg::ST_START_WR;
      gmdfs_pkg::ST_START_WR:   state_d = gmdfs_pkg::ST_POP;
      gmdfs_pkg::ST_POP: begin
        state_d = (sp_q == '0) ? gmdfs_pkg::ST_RESULT : gmdfs_pkg::ST_CHECK;
      end
      gmdfs_pkg::ST_CHECK: begin
        state_d = goal_hit ? gmdfs_pkg::ST_RESULT : gmdfs_pkg::ST_NB_ISSUE;
      end
      gmdfs_pkg::ST_NB_ISSUE: begin
        if (nb_ok) begin
          state_d = gmdfs_pkg::ST_NB_EVAL;
        end else if (dir_q == gmdfs_pkg::DIR_RIGHT) begin
          state_d = gmdfs_pkg::ST_POP;
        end
      end
      gmdfs_pkg::ST_NB_EVAL: begin
        state_d = (dir_q == gmdfs_pkg::DIR_RIGHT) ? gmdfs_pkg::ST_POP
                                                   : gmdfs_pkg::ST_NB_ISSUE;
      end
      gmdfs_pkg::ST_TRACE_RD:   state_d = gmdfs_pkg::ST_TRACE_EVAL;
      gmdfs_pkg::ST_TRACE_EVAL: state_d = gmdfs_pkg::ST_RESULT;
      gmdfs_pkg::ST_RESULT: begin
        if (ctl_i.rsp_ready) begin
          state_d = gmdfs_pkg::ST_IDLE;
        end
      end
      default: state_d = gmdfs_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    epoch_d  = epoch_q;
    pend_d   = pend_q;
    clr_d    = clr_q;
    sp_d     = sp_q;
    trace_d  = trace_q;
    start_d  = start_q;
    path_d   = path_q;
    req_d    = req_q;
    dir_d    = dir_q;
    nb_d     = nb_q;
    rsp_d    = rsp_q;
    cm_we    = 1'b0;
    cm_re    = 1'b0;
    cm_waddr = '0;
    cm_raddr = '0;
    cm_wdata = cm_rdata_q;
    st_we    = 1'b0;
    st_re    = 1'b0;
    st_waddr = '0;
    st_raddr = '0;
    st_wdata = '0;
    case (state_q)
      gmdfs_pkg::ST_CLEAR: begin
        // Read one entry and write back the previous one with its tag dropped
        clr_d = clr_q + (AW+1)'(1);
        if (!clr_q[AW]) begin
          cm_re    = 1'b1;
          cm_raddr = clr_q[AW-1:0];
        end
        if (clr_q != '0) begin
          cm_we        = 1'b1;
          cm_waddr     = AW'(clr_q - (AW+1)'(1));
          cm_wdata.tag = '0;
        end
        if (clr_q[AW] && pend_q) begin
          epoch_d = EW'(1);
          pend_d  = 1'b0;
        end
      end
      gmdfs_pkg::ST_IDLE: begin
        if (ctl_i.req_valid) begin
          req_d = req_i;
          rsp_d = '0;
          clr_d = '0;
          if (req_i.op == gmdfs_pkg::OP_SOLVE) begin
            start_d = in_addr;
            if (!start_ok) begin
              path_d = 1'b0;
            end else if (epoch_full) begin
              pend_d = 1'b1;
            end else begin
              epoch_d = epoch_q + EW'(1);
            end
          end
        end
      end
      gmdfs_pkg::ST_LOAD_RD: begin
        cm_re    = 1'b1;
        cm_raddr = req_addr;
      end
      gmdfs_pkg::ST_LOAD_WR: begin
        cm_we         = 1'b1;
        cm_waddr      = req_addr;
        cm_wdata.wall = req_q.wall;
      end
      gmdfs_pkg::ST_START_RD: begin
        cm_re    = 1'b1;
        cm_raddr = start_q;
      end
      gmdfs_pkg::ST_START_WR: begin
        // Mark the start visited and seed the stack
        cm_we        = 1'b1;
        cm_waddr     = start_q;
        cm_wdata.tag = epoch_q;
        st_we        = 1'b1;
        st_waddr     = '0;
        st_wdata     = start_q;
        sp_d         = (AW+1)'(1);
      end
      gmdfs_pkg::ST_POP: begin
        if (sp_q != '0) begin
          st_re    = 1'b1;
          st_raddr = AW'(sp_q - (AW+1)'(1));
          sp_d     = sp_q - (AW+1)'(1);
        end else begin
          path_d = 1'b0;
        end
      end
      gmdfs_pkg::ST_CHECK: begin
        dir_d = gmdfs_pkg::DIR_UP;
        if (goal_hit) begin
          rsp_d.found = 1'b1;
          path_d      = 1'b1;
          trace_d     = st_rdata_q;
        end
      end
      gmdfs_pkg::ST_NB_ISSUE: begin
        nb_d = {nb_r, nb_c};
        if (nb_ok) begin
          cm_re    = 1'b1;
          cm_raddr = {nb_r, nb_c};
        end else begin
          dir_d = gmdfs_pkg::gmdfs_dir_e'(dir_q + 2'd1);
        end
      end
      gmdfs_pkg::ST_NB_EVAL: begin
        // Push an open, unvisited neighbor and record how it was reached
        dir_d = gmdfs_pkg::gmdfs_dir_e'(dir_q + 2'd1);
        if (!cm_rdata_q.wall && (cm_rdata_q.tag != epoch_q)) begin
          cm_we        = 1'b1;
          cm_waddr     = nb_q;
          cm_wdata.dir = dir_q;
          cm_wdata.tag = epoch_q;
          st_we        = 1'b1;
          st_waddr     = sp_q[AW-1:0];
          st_wdata     = nb_q;
          sp_d         = sp_q + (AW+1)'(1);
        end
      end
      gmdfs_pkg::ST_TRACE_RD: begin
        cm_re    = 1'b1;
        cm_raddr = trace_q;
      end
      gmdfs_pkg::ST_TRACE_EVAL: begin
        rsp_d.found    = 1'b1;
        rsp_d.path_row = gmdfs_pkg::COORD_W'(trc_r);
        rsp_d.path_col = gmdfs_pkg::COORD_W'(trc_c);
        if (trace_q == start_q) begin
          rsp_d.last_of_path = 1'b1;
          path_d             = 1'b0;
        end else if (prev_ok) begin
          trace_d = {prev_r, prev_c};
        end else begin
          path_d = 1'b0;
        end
      end
      gmdfs_pkg::ST_RESULT: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gmdfs_pkg::ST_CLEAR;
      epoch_q <= '0;
      pend_q  <= 1'b0;
      clr_q   <= '0;
      sp_q    <= '0;
      trace_q <= '0;
      start_q <= '0;
      path_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      epoch_q <= epoch_d;
      pend_q  <= pend_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
      trace_q <= trace_d;
      start_q <= start_d;
      path_q  <= path_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    dir_q <= dir_d;
    nb_q  <= nb_d;
    rsp_q <= rsp_d;
  end

  // Cell memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      cell_mem[cm_waddr] <= cm_wdata;
    end
    if (cm_re) begin
      cm_rdata_q <= cell_mem[cm_raddr];
    end
  end

  // Stack memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= stack_mem[st_raddr];
    end
  end

  assign sts_o.req_ready = (state_q == gmdfs_pkg::ST_IDLE);
  assign sts_o.rsp_valid = (state_q == gmdfs_pkg::ST_RESULT);
  assign rsp_o           = rsp_q;

  `GM_ASSERT(a_push_bumps_sp, (state_q == gmdfs_pkg::ST_NB_EVAL && st_we) |=> (sp_q == $past(sp_q) + (AW+1)'(1)))
  `GM_ASSERT(a_epoch_live, (state_q == gmdfs_pkg::ST_NB_EVAL) |-> (epoch_q != '0))
  `GM_ASSERT(a_trace_needs_path, (state_q == gmdfs_pkg::ST_TRACE_RD) |-> path_q)
  `GM_ASSERT(a_hit_sets_path, (state_q == gmdfs_pkg::ST_CHECK && goal_hit) |=> (path_q && rsp_q.found))
  `GM_ASSERT_ALWAYS(a_sp_bound, sp_q <= (AW+1)'(DEPTH))

endmodule

// ===== src/grid_maze_dfs_path_finder.sv =====
// Channel  Direction  Handshake                Payload
// cfg      in         cfg_we_i                 cfg_idx_i, cfg_data_i
// in       in         in_valid_i / in_ready_o  in_req_i  (op, start, wall, goal)
// out      out        out_valid_o / out_ready_i out_rsp_o (found, path cell, last)
//
// Load and trace each read the cell memory, then write or evaluate, then respond; a
// solve reads and marks the start, then for each popped cell pops, checks, then issues
// one read and one evaluate per neighbor on the single cell memory read port.
// After reset the cell memory tags are swept; the same sweep runs before a solve each
// time the 8-bit visited epoch wraps (every 255 solves with a start in range).
// Results sit in an output register, so the next request is taken while a result
// waits; the core stalls only when a second result is ready before the first left.
module grid_maze_dfs_path_finder #(
  parameter int unsigned MAX_ROWS = gmdfs_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = gmdfs_pkg::MAX_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [gmdfs_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  gmdfs_pkg::gmdfs_req_t         in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gmdfs_pkg::gmdfs_rsp_t         out_rsp_o
);

  gmdfs_pkg::gmdfs_cfg_t cfg_q, cfg_d;
  gmdfs_pkg::gmdfs_ctl_t ctl;
  gmdfs_pkg::gmdfs_sts_t sts;
  gmdfs_pkg::gmdfs_rsp_t core_rsp;
  gmdfs_pkg::gmdfs_rsp_t out_rsp_q;
  logic                  out_valid_q;

  // Register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        gmdfs_pkg::CFG_ROWS: cfg_d.rows_in_use = cfg_data_i;
        gmdfs_pkg::CFG_COLS: cfg_d.cols_in_use = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_in_use <= gmdfs_pkg::CFG_RESET;
      cfg_q.cols_in_use <= gmdfs_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign ctl.req_valid = in_valid_i;
  assign ctl.rsp_ready = !out_valid_q || out_ready_i;
  assign in_ready_o    = sts.req_ready;

  gmdfs_core #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .req_i  (in_req_i),
    .rsp_o  (core_rsp)
  );

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sts.rsp_valid && ctl.rsp_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sts.rsp_valid && ctl.rsp_ready) begin
      out_rsp_q <= core_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
